FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge.
`define KVL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond in one cycle is followed by conseq in the next.
`define KVL_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

FILE: rtl/kvl_pkg.sv
package kvl_pkg;

  localparam int KVL_CAPACITY    = 16;
  localparam int KVL_QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] value;
  } kvl_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } kvl_result_t;

  typedef struct packed {
    logic is_insert;
    logic is_find;
    logic is_delete;
    logic is_clear;
  } kvl_class_t;

  typedef struct packed {
    kvl_class_t  cls;
    logic [31:0] key;
    logic [31:0] value;
  } kvl_req_t;

endpackage

FILE: rtl/kvl_front.sv
module kvl_front import kvl_pkg::*; (
  input  logic     start,
  output logic     busy,
  input  kvl_cmd_t cmd,
  input  logic     q_full,
  output logic     push,
  output kvl_req_t push_req
);

  kvl_class_t cls;

  always_comb begin
    cls = '0;
    unique case (cmd.operation)
      OP_INSERT: cls.is_insert = 1'b1;
      OP_FIND:   cls.is_find   = 1'b1;
      OP_DELETE: cls.is_delete = 1'b1;
      OP_CLEAR:  cls.is_clear  = 1'b1;
      default:   cls.is_clear  = 1'b1;
    endcase
  end

  assign busy           = q_full;
  assign push           = start & ~q_full;
  assign push_req.cls   = cls;
  assign push_req.key   = cmd.key;
  assign push_req.value = cmd.value;

endmodule

FILE: rtl/kvl_queue.sv
module kvl_queue import kvl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  kvl_req_t push_req,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output kvl_req_t head
);

  localparam int DEPTH = KVL_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  kvl_req_t          slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     fill;

  assign full       = (fill == NW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

FILE: rtl/kvl_back.sv
`include "assert_macros.svh"

module kvl_back import kvl_pkg::*; #(
  parameter int CAPACITY = KVL_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  kvl_req_t    req,
  output logic        pop,
  output logic        done,
  output kvl_result_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_LOAD  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t            state;
  logic [31:0]       cell_key   [CAPACITY];
  logic [31:0]       cell_value [CAPACITY];
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  kvl_req_t          cur;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] match_in;
  logic [CAPACITY-1:0] valid_mask;
  logic [CAPACITY:0]   above;
  logic [CAPACITY-1:0] newest;
  logic [CAPACITY-1:0] shift_en;
  logic [31:0]       hit_value;
  logic              hit;
  logic              ins_ok;
  logic              del_ok;
  kvl_result_t       result_next;

  assign pop = (state == S_LOAD) && req_valid;

  // Compare cells: one equality check per live entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_mask[i] = (CW'(i) < count);
      match_in[i]   = valid_mask[i] && (cell_key[i] == req.key);
    end
  end

  // Newest match is the highest set bit; everything at or above it moves down on delete.
  always_comb begin
    above[CAPACITY] = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      above[i] = above[i + 1] | match[i];
    end
    hit = above[0];
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      newest[i]   = match[i] & ~above[i + 1];
      shift_en[i] = hit & ~above[i + 1];
      hit_value   = hit_value | (cell_value[i] & {32{newest[i]}});
    end
  end

  always_comb begin
    result_next = '0;
    count_next  = count;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    if (cur.cls.is_insert) begin
      if (count == CW'(CAPACITY)) begin
        result_next.status = ST_FULL;
      end else begin
        ins_ok     = 1'b1;
        count_next = count + 1'b1;
      end
    end else if (cur.cls.is_find) begin
      if (hit) begin
        result_next.found_value = hit_value;
      end else begin
        result_next.status = ST_ABSENT;
      end
    end else if (cur.cls.is_delete) begin
      if (hit) begin
        del_ok     = 1'b1;
        count_next = count - 1'b1;
      end else begin
        result_next.status = ST_ABSENT;
      end
    end else begin
      count_next = '0;
    end
    result_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (req_valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_LOAD;
          done  <= 1'b1;
          count <= count_next;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= req;
      match <= match_in;
    end
    if (state == S_APPLY) begin
      result <= result_next;
      // Close the gap left by the deleted entry.
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (del_ok && shift_en[i]) begin
          cell_key[i]   <= cell_key[i + 1];
          cell_value[i] <= cell_value[i + 1];
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_ok && (CW'(i) == count)) begin
          cell_key[i]   <= cur.key;
          cell_value[i] <= cur.value;
        end
      end
    end
  end

  `KVL_ASSERT_NEXT(a_apply_gives_done, state == S_APPLY, done, "apply pass without a result")
  `KVL_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count beyond capacity")
  `KVL_ASSERT(a_match_live, (state == S_APPLY) |-> ((match & ~valid_mask) == '0), "match on a dead entry")

endmodule

FILE: rtl/key_value_list_table_unit.sv
// Key/value table kept in insertion order, newest entry on top.
// Request channel: drive cmd (operation, key, value) and raise start; the
// request is taken at a rising edge where start is high and busy is low.
// Operations: insert a pair, find the newest value for a key, delete the
// newest entry with a key (later entries close the gap), clear the table.
// Result channel: done is high for one cycle with result (status,
// found_value, entry_count); the receiver takes it in that cycle and cannot
// hold it off.
// A two-entry queue sits between the request side and the table engine;
// busy is high only while that queue is full.
// Each request takes the engine's two passes in order (compare every cell
// against the key, then update cells and count); done is registered in the
// update pass. The queue keeps taking requests until it is full, but the
// engine starts the next one only after the update pass of the last one.
// Reset (rst, synchronous): empties the table and the queue, drops done.
module key_value_list_table_unit import kvl_pkg::*; #(
  parameter int CAPACITY = KVL_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  kvl_cmd_t    cmd,
  output logic        done,
  output kvl_result_t result
);

  logic     push;
  kvl_req_t push_req;
  logic     q_full;
  logic     pop;
  logic     head_valid;
  kvl_req_t head;

  kvl_front u_front (
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  kvl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  kvl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (head_valid),
    .req       (head),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule
